// ----- src/ttcr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttcr_pkg
// Shared types and constants for the tunnel table with commit and rollback.
// ----------------------------------------------------------------------------
package ttcr_pkg;

	localparam int SLOTS  = 1024;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int KEY_W  = 32;

	localparam logic [KEY_W-1:0] IP_PDUS = 32'hC0A8_0002;
	localparam logic [KEY_W-1:0] IP_DRB  = 32'hC0A8_0001;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FAIL     = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_GET      = 3'd1,
		OP_ADD      = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_MODIFY   = 3'd4,
		OP_COMMIT   = 3'd5,
		OP_ROLLBACK = 3'd6,
		OP_BAD      = 3'd7
	} op_t;

	// classified item as it leaves the front part
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key_ip;
		logic [KEY_W-1:0] key_teid;
		logic             type_ok;
		logic [KEY_W-1:0] alloc_ip;
		logic [SLOT_W-1:0] hslot;
		logic             handle_ok;
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  ip;
		logic [KEY_W-1:0]  teid;
		logic [SLOT_W-1:0] slot;
	} map_ent_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_START,
		ST_KEY_RD,
		ST_KEY_EV,
		ST_FIND_RD,
		ST_FIND_EV,
		ST_DECIDE,
		ST_OLD_RD,
		ST_OLD_EV,
		ST_SLOT_RD,
		ST_SLOT_EV,
		ST_IDCLR,
		ST_IDMARK_RD,
		ST_IDMARK_EV,
		ST_IDSRCH_RD,
		ST_IDSRCH_EV
	} state_t;

endpackage
`default_nettype wire

// ----- src/ttcr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttcr_front
// Accepts items, decodes opcode, tunnel type and handle into a command.
// ----------------------------------------------------------------------------
module ttcr_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [2:0]               opcode,
	input  wire logic [31:0]              key_ip,
	input  wire logic [31:0]              key_teid,
	input  wire logic [1:0]               tun_kind,
	input  wire logic [9:0]               handle_slot,
	input  wire logic                     handle_valid,
	output logic                          cmd_valid,
	output ttcr_pkg::cmd_t                cmd,
	input  wire logic                     cmd_ready
);
	import ttcr_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic accept;

	always_comb begin
		dec.op        = op_t'(opcode);
		dec.key_ip    = key_ip;
		dec.key_teid  = key_teid;
		dec.type_ok   = (tun_kind == 2'd0) || (tun_kind == 2'd1);
		dec.alloc_ip  = (tun_kind == 2'd0) ? IP_PDUS : IP_DRB;
		dec.hslot     = handle_slot;
		dec.handle_ok = handle_valid && (int'(handle_slot) < SLOTS);
	end

	assign full      = valid_s1 && !cmd_ready;
	assign accept    = push && !full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule
`default_nettype wire

// ----- src/ttcr_cmdq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttcr_cmdq
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ttcr_cmdq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  ttcr_pkg::cmd_t      wr_data,
	output logic                wr_ready,
	output logic                rd_valid,
	input  wire logic           rd_en,
	output ttcr_pkg::cmd_t      rd_data
);
	import ttcr_pkg::*;

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = ent_q[rptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= !wptr_q;
			end
			if (do_rd) begin
				rptr_q <= !rptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ----- src/ttcr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ttcr_back
// Sequencer over slot, key, map and id-scratch memories; holds the result.
// ----------------------------------------------------------------------------
module ttcr_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  ttcr_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  wire logic         pop,
	output logic [1:0]        status,
	output logic [9:0]        result_slot,
	output logic              slot_valid,
	output logic [31:0]       out_ip,
	output logic [9:0]        out_teid
);
	import ttcr_pkg::*;

	// memories
	logic                 used_mem [SLOTS];
	logic [2*KEY_W-1:0]   key_mem  [SLOTS];
	map_ent_t             map_mem  [SLOTS];
	logic                 id_mem   [SLOTS];

	logic                 used_we, used_wdata, used_rdata;
	logic [SLOT_W-1:0]    used_waddr, used_raddr;
	logic                 key_we;
	logic [2*KEY_W-1:0]   key_wdata, key_rdata;
	logic [SLOT_W-1:0]    key_waddr, key_raddr;
	logic                 map_we;
	map_ent_t             map_wdata, map_rdata;
	logic [SLOT_W-1:0]    map_waddr, map_raddr;
	logic                 id_we, id_wdata, id_rdata;
	logic [SLOT_W-1:0]    id_waddr, id_raddr;

	state_t               state_q, state_d;
	logic [SLOT_W-1:0]    cnt_q, cnt_nxt;
	logic                 cnt_last;
	logic                 ready_q;
	logic [SLOT_W-1:0]    last_slot_q, last_id_q;
	cmd_t                 cmd_q;
	logic [KEY_W-1:0]     skey_ip_q, skey_teid_q;
	logic                 nt_used_q;
	logic                 found_q, free_ok_q;
	logic [SLOT_W-1:0]    fidx_q, fslot_q, free_idx_q;
	logic                 key_hit;

	logic                 res_valid_q;
	logic [1:0]           res_status_q;
	logic [SLOT_W-1:0]    res_slot_q, res_teid_q;
	logic                 res_sval_q;
	logic [KEY_W-1:0]     res_ip_q;

	logic                 fin, fin_sval;
	logic [1:0]           fin_status;
	logic [SLOT_W-1:0]    fin_slot, fin_teid;
	logic [KEY_W-1:0]     fin_ip;

	function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] x);
		logic [SLOT_W-1:0] r;
		r = (x == SLOT_W'(SLOTS - 1)) ? '0 : x + SLOT_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_waddr] <= used_wdata;
		end
		used_rdata <= used_mem[used_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		key_rdata <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rdata <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[id_waddr] <= id_wdata;
		end
		id_rdata <= id_mem[id_raddr];
	end

	assign cnt_last = (cnt_q == SLOT_W'(SLOTS - 1));
	assign cnt_nxt  = wrap_inc(cnt_q);
	assign key_hit  = map_rdata.valid && (map_rdata.ip == skey_ip_q)
		&& (map_rdata.teid == skey_teid_q);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid && !res_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:       if (cnt_last) state_d = ST_IDLE;
			ST_IDLE:      if (cmd_valid && !res_valid_q) state_d = ST_START;
			ST_START: begin
				unique case (cmd_q.op)
					OP_ALLOC:  state_d = cmd_q.type_ok ? ST_IDCLR : ST_IDLE;
					OP_ADD:    state_d = ST_FIND_RD;
					OP_GET, OP_REMOVE, OP_MODIFY:
						state_d = ready_q ? ST_FIND_RD : ST_IDLE;
					OP_COMMIT, OP_ROLLBACK:
						state_d = (ready_q && cmd_q.handle_ok) ? ST_KEY_RD : ST_IDLE;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_KEY_RD:    state_d = ST_KEY_EV;
			ST_KEY_EV:    state_d = ST_FIND_RD;
			ST_FIND_RD:   state_d = ST_FIND_EV;
			ST_FIND_EV:   state_d = cnt_last ? ST_DECIDE : ST_FIND_RD;
			ST_DECIDE: begin
				unique case (cmd_q.op)
					OP_ADD:      state_d = found_q ? ST_IDLE : ST_SLOT_RD;
					OP_MODIFY:   state_d = found_q ? ST_SLOT_RD : ST_IDLE;
					OP_ROLLBACK: state_d = (found_q && fslot_q != cmd_q.hslot)
						? ST_OLD_RD : ST_IDLE;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_OLD_RD:    state_d = ST_OLD_EV;
			ST_OLD_EV:    state_d = ST_IDLE;
			ST_SLOT_RD:   state_d = ST_SLOT_EV;
			ST_SLOT_EV:   state_d = (!used_rdata || cnt_nxt == last_slot_q)
				? ST_IDLE : ST_SLOT_RD;
			ST_IDCLR:     if (cnt_last) state_d = ST_IDMARK_RD;
			ST_IDMARK_RD: state_d = ST_IDMARK_EV;
			ST_IDMARK_EV: state_d = cnt_last ? ST_IDSRCH_RD : ST_IDMARK_RD;
			ST_IDSRCH_RD: state_d = ST_IDSRCH_EV;
			ST_IDSRCH_EV: state_d = (!id_rdata || cnt_nxt == last_id_q)
				? ST_IDLE : ST_IDSRCH_RD;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory control and result
	always_comb begin
		used_we    = 1'b0;
		used_waddr = cnt_q;
		used_wdata = 1'b0;
		used_raddr = cnt_q;
		key_we     = 1'b0;
		key_waddr  = cnt_q;
		key_wdata  = {skey_ip_q, skey_teid_q};
		key_raddr  = cmd_q.hslot;
		map_we     = 1'b0;
		map_waddr  = cnt_q;
		map_wdata  = '0;
		map_raddr  = cnt_q;
		id_we      = 1'b0;
		id_waddr   = cnt_q;
		id_wdata   = 1'b0;
		id_raddr   = cnt_q;
		fin        = 1'b0;
		fin_status = STAT_FAIL;
		fin_slot   = '0;
		fin_sval   = 1'b0;
		fin_ip     = '0;
		fin_teid   = '0;
		unique case (state_q)
			ST_CLR: begin
				used_we = 1'b1;
				map_we  = 1'b1;
			end
			ST_START: begin
				unique case (cmd_q.op)
					OP_ALLOC:  fin = !cmd_q.type_ok;
					OP_ADD:    fin = 1'b0;
					OP_GET, OP_REMOVE, OP_MODIFY: fin = !ready_q;
					OP_COMMIT, OP_ROLLBACK: fin = !(ready_q && cmd_q.handle_ok);
					default:   fin = 1'b1;
				endcase
			end
			ST_KEY_RD: begin
				used_raddr = cmd_q.hslot;
			end
			ST_DECIDE: begin
				unique case (cmd_q.op)
					OP_GET: begin
						fin = 1'b1;
						if (found_q) begin
							fin_status = STAT_OK;
							fin_slot   = fslot_q;
							fin_sval   = 1'b1;
						end else begin
							fin_status = STAT_NOTFOUND;
						end
					end
					OP_REMOVE: begin
						fin = 1'b1;
						if (found_q) begin
							used_we    = 1'b1;
							used_waddr = fslot_q;
							fin_status = STAT_OK;
						end else begin
							fin_status = STAT_NOTFOUND;
						end
					end
					OP_ADD: fin = found_q;
					OP_MODIFY: begin
						fin        = !found_q;
						fin_status = STAT_NOTFOUND;
					end
					OP_COMMIT: begin
						fin        = 1'b1;
						fin_status = STAT_OK;
						if (!found_q) begin
							if (free_ok_q) begin
								map_we    = 1'b1;
								map_waddr = free_idx_q;
								map_wdata = {1'b1, skey_ip_q, skey_teid_q, cmd_q.hslot};
							end else begin
								fin_status = STAT_FAIL;
							end
						end else if (fslot_q == cmd_q.hslot) begin
							map_we    = !nt_used_q;
							map_waddr = fidx_q;
							map_wdata = {1'b0, skey_ip_q, skey_teid_q, fslot_q};
						end else begin
							used_we    = 1'b1;
							used_waddr = fslot_q;
							map_we     = 1'b1;
							map_waddr  = fidx_q;
							map_wdata  = {1'b1, skey_ip_q, skey_teid_q, cmd_q.hslot};
						end
					end
					OP_ROLLBACK: begin
						used_waddr = cmd_q.hslot;
						if (!found_q) begin
							fin        = 1'b1;
							used_we    = nt_used_q;
							fin_status = nt_used_q ? STAT_OK : STAT_FAIL;
						end else if (fslot_q == cmd_q.hslot) begin
							fin        = 1'b1;
							used_we    = 1'b1;
							used_wdata = 1'b1;
							fin_status = STAT_OK;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_OLD_RD: begin
				used_raddr = fslot_q;
			end
			ST_OLD_EV: begin
				fin        = 1'b1;
				used_waddr = cmd_q.hslot;
				if (nt_used_q && used_rdata) begin
					used_we    = 1'b1;
					fin_status = STAT_OK;
				end
			end
			ST_SLOT_EV: begin
				if (!used_rdata) begin
					used_we    = 1'b1;
					used_wdata = 1'b1;
					key_we     = 1'b1;
					fin        = 1'b1;
					fin_status = STAT_OK;
					fin_slot   = cnt_q;
					fin_sval   = 1'b1;
				end else if (cnt_nxt == last_slot_q) begin
					fin = 1'b1;
				end
			end
			ST_IDCLR: begin
				id_we = 1'b1;
			end
			ST_IDMARK_EV: begin
				id_waddr = map_rdata.teid[SLOT_W-1:0];
				id_wdata = 1'b1;
				id_we    = map_rdata.valid && (map_rdata.ip == cmd_q.alloc_ip)
					&& (map_rdata.teid[KEY_W-1:SLOT_W] == '0);
			end
			ST_IDSRCH_EV: begin
				if (!id_rdata) begin
					fin        = 1'b1;
					fin_status = STAT_OK;
					fin_ip     = cmd_q.alloc_ip;
					fin_teid   = cnt_q;
				end else if (cnt_nxt == last_id_q) begin
					fin = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			last_slot_q <= '0;
			last_id_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLR, ST_FIND_EV, ST_IDCLR, ST_SLOT_EV, ST_IDSRCH_EV:
					cnt_q <= cnt_nxt;
				ST_START:     cnt_q <= '0;
				ST_DECIDE:    cnt_q <= wrap_inc(last_slot_q);
				ST_IDMARK_EV: cnt_q <= cnt_last ? wrap_inc(last_id_q) : cnt_nxt;
				default:      cnt_q <= cnt_q;
			endcase
			if (state_q == ST_START && (cmd_q.op == OP_ALLOC || cmd_q.op == OP_ADD)) begin
				ready_q <= 1'b1;
			end
			if (state_q == ST_SLOT_EV && !used_rdata) begin
				last_slot_q <= cnt_q;
			end
			if (state_q == ST_IDSRCH_EV && !id_rdata) begin
				last_id_q <= cnt_q;
			end
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_START) begin
			found_q     <= 1'b0;
			free_ok_q   <= 1'b0;
			skey_ip_q   <= cmd_q.key_ip;
			skey_teid_q <= cmd_q.key_teid;
		end
		if (state_q == ST_KEY_EV) begin
			skey_ip_q   <= key_rdata[2*KEY_W-1:KEY_W];
			skey_teid_q <= key_rdata[KEY_W-1:0];
			nt_used_q   <= used_rdata;
		end
		if (state_q == ST_FIND_EV) begin
			if (key_hit && !found_q) begin
				found_q <= 1'b1;
				fidx_q  <= cnt_q;
				fslot_q <= map_rdata.slot;
			end
			if (!map_rdata.valid && !free_ok_q) begin
				free_ok_q  <= 1'b1;
				free_idx_q <= cnt_q;
			end
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_slot_q   <= fin_slot;
			res_sval_q   <= fin_sval;
			res_ip_q     <= fin_ip;
			res_teid_q   <= fin_teid;
		end
	end

	assign empty       = !res_valid_q;
	assign status      = res_status_q;
	assign result_slot = res_slot_q;
	assign slot_valid  = res_sval_q;
	assign out_ip      = res_ip_q;
	assign out_teid    = res_teid_q;

endmodule
`default_nettype wire

// ----- src/tunnel_table_with_commit_rollback.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tunnel_table_with_commit_rollback
// Tunnel slot table with an exact-match key map, commit and rollback.
// ----------------------------------------------------------------------------
// Input channel: push/full. An item (opcode, key, tunnel type, handle) is
//   taken when push is high and full is low. A decode stage and a two-entry
//   command queue buffer up to three items ahead of the sequencer.
// Result channel: empty/pop. One result item per input item, in order; the
//   result register holds it until popped. While a result waits the
//   sequencer holds, but the input side keeps filling its queue.
// Operation: every map lookup sweeps all 1024 map entries, each with a
//   registered memory read and then an evaluation. get/remove: a lookup.
//   add/modify: lookup plus a round-robin slot scan. commit/rollback: a key
//   read, then a lookup. alloc_id: clears a 1024-entry id scratch memory,
//   marks ids from one map sweep, then scans ids round-robin. Rejected
//   items finish straight from the start state.
// Reset: arst_n clears control state; the back part then sweeps all 1024
//   slots clearing the used marks and map valid bits, taking no item.
// ----------------------------------------------------------------------------
module tunnel_table_with_commit_rollback (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] key_ip,
	input  wire logic [31:0] key_teid,
	input  wire logic [1:0]  tun_kind,
	input  wire logic [9:0]  handle_slot,
	input  wire logic        handle_valid,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [9:0]       result_slot,
	output logic             slot_valid,
	output logic [31:0]      out_ip,
	output logic [9:0]       out_teid
);
	import ttcr_pkg::*;

	// front stage to queue
	logic fr_valid;
	cmd_t fr_cmd;
	logic q_ready;
	// queue to sequencer
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	ttcr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.key_ip       (key_ip),
		.key_teid     (key_teid),
		.tun_kind     (tun_kind),
		.handle_slot  (handle_slot),
		.handle_valid (handle_valid),
		.cmd_valid    (fr_valid),
		.cmd          (fr_cmd),
		.cmd_ready    (q_ready)
	);

	ttcr_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_valid),
		.wr_data  (fr_cmd),
		.wr_ready (q_ready),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_data  (q_cmd)
	);

	// sequencer owns all table memories and the result register
	ttcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.result_slot (result_slot),
		.slot_valid  (slot_valid),
		.out_ip      (out_ip),
		.out_teid    (out_teid)
	);

endmodule
`default_nettype wire
